// ===== design/gyri_pkg.sv =====
// ----------------------------------------------------------------------------
// gyri_pkg: shared definitions for the gyro rate angle integrator
// Angle and turn widths, reset values, item codes and the lane control bundle.
// ----------------------------------------------------------------------------
package gyri_pkg;

    // Field widths fixed by the angle format
    localparam int ANGLE_W  = 48;
    localparam int TURN_W   = 40;
    // The product is clamped to +/- 2^48, which needs 50 signed bits
    localparam int CLIP_W   = 50;

    // Defaults for the top-level parameters
    localparam int RATE_WIDTH_DEF  = 16;
    localparam int STAMP_WIDTH_DEF = 32;

    // Reset value of the full-turn register (360 degrees in angle units)
    localparam logic [TURN_W-1:0] TURN_RESET = 40'd24000000;

    // Item kind carried in tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Pipeline control handed from the top level to each lane
    typedef struct packed {
        logic ld_rate;  // stage 1 captures the incoming rate
        logic ld_prod;  // stage 2 captures the product
        logic ld_clip;  // stage 3 captures the clamped product
        logic acc;      // stage 3 item is consumed by the accumulator
        logic clr;      // the consumed item is a clear request
    } t_lane_ctl;

endpackage

// ===== design/gyri_lane.sv =====
// ----------------------------------------------------------------------------
// gyri_lane: one axis of the rate integrator
// Multiplies the rate by the stamp difference, clamps the product, adds it to
// the angle with saturation and applies one wrap correction by a full turn.
// ----------------------------------------------------------------------------
module gyri_lane #(
    parameter int RATE_WIDTH  = gyri_pkg::RATE_WIDTH_DEF,
    parameter int STAMP_WIDTH = gyri_pkg::STAMP_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gyri_pkg::t_lane_ctl                i_ctl,
    input  logic signed [RATE_WIDTH-1:0]       i_rate,
    input  logic signed [STAMP_WIDTH-1:0]      i_dt,
    input  logic [gyri_pkg::TURN_W-1:0]        i_full_turn,
    output logic signed [gyri_pkg::ANGLE_W-1:0] o_angle_next
);
    import gyri_pkg::*;

    localparam int PROD_W = RATE_WIDTH + STAMP_WIDTH;
    localparam int EXT_W  = (PROD_W > CLIP_W) ? PROD_W : CLIP_W;
    localparam int SUM_W  = CLIP_W + 1;
    localparam int WRAP_W = ANGLE_W + 1;

    localparam logic signed [EXT_W-1:0] CLIP_HI =
        {{(EXT_W-CLIP_W+1){1'b0}}, 1'b1, {(CLIP_W-2){1'b0}}};
    localparam logic signed [EXT_W-1:0] CLIP_LO = -CLIP_HI;

    logic signed [RATE_WIDTH-1:0] r_rate;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [CLIP_W-1:0]     r_clip;
    logic signed [ANGLE_W-1:0]    r_angle;

    logic signed [EXT_W-1:0]      prod_ext;
    logic signed [CLIP_W-1:0]     n_clip;
    logic signed [SUM_W-1:0]      sum;
    logic signed [ANGLE_W-1:0]    sat;
    logic signed [WRAP_W-1:0]     sat_ext;
    logic signed [WRAP_W-1:0]     turn_ext;
    logic signed [WRAP_W-1:0]     wrapped;

    // Stage 1 holds the rate beside the stamp difference from the top level
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_rate) begin
            r_rate <= i_rate;
        end
    end

    // Stage 2: the multiplication
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_prod <= PROD_W'(r_rate * i_dt);
        end
    end

    // Stage 3: clamp the product to +/- 2^48
    always_comb begin
        prod_ext = EXT_W'(r_prod);
        if (prod_ext > CLIP_HI) begin
            n_clip = CLIP_HI[CLIP_W-1:0];
        end else if (prod_ext < CLIP_LO) begin
            n_clip = CLIP_LO[CLIP_W-1:0];
        end else begin
            n_clip = prod_ext[CLIP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_clip) begin
            r_clip <= n_clip;
        end
    end

    // Accumulate, saturate to 48 bits, then one wrap correction
    always_comb begin
        sum = SUM_W'(r_angle) + SUM_W'(r_clip);
        if (sum[SUM_W-1:ANGLE_W-1] == '0 || sum[SUM_W-1:ANGLE_W-1] == '1) begin
            sat = sum[ANGLE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            sat = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        sat_ext  = WRAP_W'(sat);
        turn_ext = WRAP_W'({1'b0, i_full_turn});
        if (sat_ext < -turn_ext) begin
            wrapped = sat_ext + turn_ext;
        end else if (sat_ext > turn_ext) begin
            wrapped = sat_ext - turn_ext;
        end else begin
            wrapped = sat_ext;
        end
        o_angle_next = wrapped[ANGLE_W-1:0];
    end

    // Angle register: cleared by a clear request, else takes the new angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_ctl.acc) begin
            if (i_ctl.clr) begin
                r_angle <= '0;
            end else begin
                r_angle <= o_angle_next;
            end
        end
    end

endmodule

// ===== design/gyri_merge.sv =====
// ----------------------------------------------------------------------------
// gyri_merge: result register for the three lanes
// Joins pitch, roll and yaw into one result and holds it until it is taken.
// ----------------------------------------------------------------------------
module gyri_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [gyri_pkg::ANGLE_W-1:0] i_pitch,
    input  logic signed [gyri_pkg::ANGLE_W-1:0] i_roll,
    input  logic signed [gyri_pkg::ANGLE_W-1:0] i_yaw,
    input  logic                                i_ready,
    output logic                                o_free,
    output logic                                o_valid,
    output logic [3*gyri_pkg::ANGLE_W-1:0]      o_data
);
    import gyri_pkg::*;

    logic                   r_valid;
    logic [3*ANGLE_W-1:0]   r_data;

    // The register can take a new result when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_yaw, i_roll, i_pitch};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/gyro_rate_angle_integrator.sv =====
// ----------------------------------------------------------------------------
// gyro_rate_angle_integrator: gyro rate to pitch, roll and yaw angles
// Integrates three signed rates over the stamp difference in parallel lanes.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while s_axis_tready is high. A
// sample request after arming passes stages 1 to 3 into the result register,
// which presents its angles; clear requests and samples taken before arming
// yield nothing. Each axis has its own lane with one multiplier, and the angle
// accumulator in each lane closes its loop through its angle register, which
// sets the rate of one request per cycle. Input keeps flowing while a result
// waits in the output register, until the three internal stages have filled.
// The full_turn register may be written only while no request is in flight.
module gyro_rate_angle_integrator #(
    parameter int RATE_WIDTH  = gyri_pkg::RATE_WIDTH_DEF,
    parameter int STAMP_WIDTH = gyri_pkg::STAMP_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration: full_turn
    input  logic                                 i_cfg_wr_en,
    input  logic [gyri_pkg::TURN_W-1:0]          i_cfg_wr_data,
    // Request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, low bits up: rate_x, rate_y, rate_z, stamp, zero pad
    input  logic [((3*RATE_WIDTH+STAMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: func
    input  logic                                 s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, low bits up: pitch, roll, yaw
    output logic [3*gyri_pkg::ANGLE_W-1:0]       m_axis_tdata
);
    import gyri_pkg::*;

    localparam int NUM_LANES = 3;

    logic [TURN_W-1:0]              r_full_turn;
    logic                           r_armed;
    logic [STAMP_WIDTH-1:0]         r_last_stamp;
    logic                           r_v1, r_v2, r_v3;
    logic                           r_c1, r_c2, r_c3;
    logic signed [STAMP_WIDTH-1:0]  r_dt;

    logic                           accept;
    logic                           go1, go2, go3, take3;
    logic                           out_free;
    logic                           is_clear;
    logic                           rates_nonzero;
    logic                           n_v1;
    logic [STAMP_WIDTH-1:0]         in_stamp;
    logic signed [RATE_WIDTH-1:0]   in_rate [NUM_LANES];
    logic signed [ANGLE_W-1:0]      angle_next [NUM_LANES];
    t_lane_ctl                      lane_ctl;

    // Unpack the request
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            in_rate[k] = s_axis_tdata[k*RATE_WIDTH +: RATE_WIDTH];
        end
        in_stamp = s_axis_tdata[NUM_LANES*RATE_WIDTH +: STAMP_WIDTH];
    end

    assign is_clear      = (s_axis_tuser == FUNC_CLEAR);
    assign rates_nonzero = (in_rate[0] != '0) && (in_rate[1] != '0) && (in_rate[2] != '0);

    // Stall chain: a stage loads when it is empty or its item moves on
    assign take3         = r_v3 && (r_c3 || out_free);
    assign go3           = !r_v3 || take3;
    assign go2           = !r_v2 || go3;
    assign go1           = !r_v1 || go2;
    assign s_axis_tready = go1;
    assign accept        = s_axis_tvalid && go1;

    // Only clears and armed samples enter the pipeline
    assign n_v1 = accept && (is_clear || r_armed);

    // Full-turn register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_turn <= TURN_RESET;
        end else if (i_cfg_wr_en) begin
            r_full_turn <= i_cfg_wr_data;
        end
    end

    // Arming and the previous stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_last_stamp <= '0;
        end else if (accept) begin
            if (is_clear) begin
                r_armed <= 1'b0;
            end else if (!r_armed) begin
                if (rates_nonzero) begin
                    r_armed      <= 1'b1;
                    r_last_stamp <= in_stamp;
                end
            end else begin
                r_last_stamp <= in_stamp;
            end
        end
    end

    // Stage 1: stamp difference, modulo the stamp width and read as signed
    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_dt <= in_stamp - r_last_stamp;
            r_c1 <= is_clear;
        end
    end

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (go1) begin
                r_v1 <= n_v1;
            end
            if (go2) begin
                r_v2 <= r_v1;
            end
            if (go3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Clear flags travel beside the items through the stages
    always_ff @(posedge i_clk) begin
        if (go2) begin
            r_c2 <= r_c1;
        end
        if (go3) begin
            r_c3 <= r_c2;
        end
    end

    // Lane control
    always_comb begin
        lane_ctl.ld_rate = go1;
        lane_ctl.ld_prod = go2;
        lane_ctl.ld_clip = go3;
        lane_ctl.acc     = take3;
        lane_ctl.clr     = r_c3;
    end

    // One lane per axis: x drives pitch, y roll, z yaw
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        gyri_lane #(
            .RATE_WIDTH  (RATE_WIDTH),
            .STAMP_WIDTH (STAMP_WIDTH)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (lane_ctl),
            .i_rate       (in_rate[g]),
            .i_dt         (r_dt),
            .i_full_turn  (r_full_turn),
            .o_angle_next (angle_next[g])
        );
    end

    // Merge the three angles into one result
    gyri_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take3 && !r_c3),
        .i_pitch (angle_next[0]),
        .i_roll  (angle_next[1]),
        .i_yaw   (angle_next[2]),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule
